@@ sv/rbtq_pkg.sv @@
// Shared constants, types and helpers for the repeated-block trace query block.
package rbtq_pkg;

  localparam int MAX_BLOCKS  = 64;
  localparam int TRACE_BITS  = 4096;
  localparam int WORD_WIDTH  = 32;
  localparam int STORE_WORDS = TRACE_BITS / WORD_WIDTH;

  localparam int IDX_W    = 6;
  localparam int CNT_W    = 7;
  localparam int WADDR_W  = 7;
  localparam int BIT_W    = 5;
  localparam int SAMPLE_W = 32;
  localparam int OFF_W    = 12;
  localparam int LEN_W    = 13;
  localparam int REP_W    = 32;
  localparam int TLEN_W   = 45;
  localparam int SPAN_W   = 14;
  localparam int IN_W     = 200;
  localparam int OUT_W    = 48;

  typedef enum logic [1:0] {
    CMD_ENTRY = 2'd0,
    CMD_WORD  = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_FIND,
    ST_DIV_F,
    ST_WAIT_F,
    ST_DIV_L,
    ST_WAIT_L,
    ST_FBIT_RD,
    ST_FBIT_CHK,
    ST_PLAN,
    ST_PART_B,
    ST_PART_C,
    ST_C_RD_L,
    ST_C_RD_F,
    ST_C_SET,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_LEN_RD,
    ST_LEN_MUL,
    ST_LEN_ADD,
    ST_DONE
  } state_t;

  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
    eff_len = (len == '0) ? LEN_W'(1) : len;
  endfunction

endpackage

@@ sv/repeated_block_trace_query.sv @@
// Top level: block table, query sequencer and trace length unit.
// Usage:
//   cfg_wr_en/cfg_wr_data write blocks_in_use; write only while idle.
//   Input transactions (in_tvalid/in_tready) carry the command in in_tuser:
//   entry write, data word write or range query. Every transaction yields
//   exactly one output transaction on out_tvalid/out_tready.
// Sequence:
//   a load goes from acceptance through the trace length read, multiply and
//   add steps, then the output step; the next one is taken back in idle.
//   A query runs a table search over the n blocks in use, two divisions on
//   the shared divider when both bounds hit a block, then up to three range
//   scans that read and check each store word touched, then the trace length steps.
// Throughput: one transaction at a time; in_tready is high only when idle.
// A finished result waits in the output register; a stalled receiver holds
// the sequencer in its final step until the register frees.
// Reset: synchronous active-low; clears control and blocks_in_use. The table
// and store are undefined until written.
module repeated_block_trace_query import rbtq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [CNT_W-1:0]  cfg_wr_data,
  input  logic              in_tvalid,
  output logic              in_tready,
  // entry_index, start_sample, bit_offset, pattern_length, repeats,
  // word_address, word_bits, range_first, range_last, zero pad
  input  logic [IN_W-1:0]   in_tdata,
  // cmd
  input  logic [1:0]        in_tuser,
  output logic              out_tvalid,
  input  logic              out_tready,
  // first_bit, saw_low, saw_high, trace_length
  output logic [OUT_W-1:0]  out_tdata,
  // out_of_range
  output logic              out_tuser
);

  logic [IDX_W-1:0]      in_entry;
  logic [SAMPLE_W-1:0]   in_start;
  logic [OFF_W-1:0]      in_off;
  logic [LEN_W-1:0]      in_len;
  logic [REP_W-1:0]      in_rep;
  logic [WADDR_W-1:0]    in_waddr;
  logic [WORD_WIDTH-1:0] in_wbits;
  logic [SAMPLE_W-1:0]   in_first;
  logic [SAMPLE_W-1:0]   in_last;
  cmd_t                  in_cmd;

  assign in_entry = in_tdata[5:0];
  assign in_start = in_tdata[37:6];
  assign in_off   = in_tdata[49:38];
  assign in_len   = in_tdata[62:50];
  assign in_rep   = in_tdata[94:63];
  assign in_waddr = in_tdata[101:95];
  assign in_wbits = in_tdata[133:102];
  assign in_first = in_tdata[165:134];
  assign in_last  = in_tdata[197:166];
  assign in_cmd   = cmd_t'(in_tuser);

  state_t state_r, state_nxt, ret_r;
  logic   accept;
  logic [CNT_W-1:0] cfg_r;
  logic [CNT_W-1:0] n_blk;

  assign accept = in_tvalid && in_tready;
  assign n_blk  = (cfg_r > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) cfg_r <= '0;
    else if (cfg_wr_en) cfg_r <= cfg_wr_data;
  end

  // block table
  logic [SAMPLE_W-1:0] tb_start [MAX_BLOCKS];
  logic [OFF_W-1:0]    tb_off   [MAX_BLOCKS];
  logic [LEN_W-1:0]    tb_len   [MAX_BLOCKS];
  logic [REP_W-1:0]    tb_rep   [MAX_BLOCKS];
  logic [IDX_W-1:0]    tb_addr;
  logic [SAMPLE_W-1:0] q_start_r;
  logic [OFF_W-1:0]    q_off_r;
  logic [LEN_W-1:0]    q_len_r;
  logic [REP_W-1:0]    q_rep_r;

  always_ff @(posedge clk) begin
    if (accept && in_cmd == CMD_ENTRY) begin
      tb_start[in_entry] <= in_start;
      tb_off[in_entry]   <= in_off;
      tb_len[in_entry]   <= in_len;
      tb_rep[in_entry]   <= in_rep;
    end
    q_start_r <= tb_start[tb_addr];
    q_off_r   <= tb_off[tb_addr];
    q_len_r   <= tb_len[tb_addr];
    q_rep_r   <= tb_rep[tb_addr];
  end

  // query registers
  logic [SAMPLE_W-1:0] first_r, last_r;
  logic [CNT_W-1:0]    idx_r;
  logic                pv_r;
  logic [IDX_W-1:0]    pidx_r;
  logic                f_hit_r, l_hit_r;
  logic [IDX_W-1:0]    f_idx_r, l_idx_r;
  logic [SAMPLE_W-1:0] f_start_r, l_start_r;
  logic [OFF_W-1:0]    f_off_r, l_off_r;
  logic [LEN_W-1:0]    f_len_r, l_len_r;
  logic [REP_W-1:0]    f_rep_r;
  logic [SAMPLE_W-1:0] fri_r, lri_r;
  logic [LEN_W-1:0]    fro_r, lro_r;
  logic                fbit_r, lo_r, hi_r, oor_r, done_r;
  logic signed [7:0]   fc_r, lc_r;
  logic [SPAN_W-1:0]   seg_a_r, seg_b_r;
  logic [TLEN_W-1:0]   prod_r, tlen_r;
  logic                out_valid_r;
  logic [OUT_W-1:0]    out_data_r;
  logic                out_oor_r;

  // shared divider
  logic                div_start, div_busy;
  logic [SAMPLE_W-1:0] div_dvd, div_quo;
  logic [LEN_W-1:0]    div_dvs, div_rem;

  rbtq_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .quotient (div_quo),
    .remainder(div_rem)
  );

  // bit store
  logic [WADDR_W-1:0]    st_addr;
  logic [WORD_WIDTH-1:0] st_data;

  rbtq_store u_store (
    .clk    (clk),
    .wr_en  (accept && in_cmd == CMD_WORD),
    .wr_addr(in_waddr),
    .wr_data(in_wbits),
    .rd_addr(st_addr),
    .rd_data(st_data)
  );

  // derived values
  logic [SPAN_W-1:0] fpos;
  logic              same_rep, cond_a, cond_c, find_end, slot_free, scan_end;
  logic [SPAN_W-1:0] cnt;
  logic [5:0]        room, hi_ex;
  logic [WORD_WIDTH-1:0] mask;

  assign fpos      = SPAN_W'(f_off_r) + SPAN_W'(fro_r);
  assign same_rep  = (f_idx_r == l_idx_r) && (fri_r == lri_r);
  assign cond_a    = (f_rep_r != '0) && (fri_r == f_rep_r - REP_W'(1));
  assign cond_c    = !done_r && (fc_r <= lc_r) && (fc_r < $signed({1'b0, n_blk}))
                     && (lc_r >= 8'sd0);
  assign find_end  = (idx_r >= n_blk) && !pv_r;
  assign slot_free = !out_valid_r || out_tready;
  assign scan_end  = (seg_a_r >= seg_b_r) || (lo_r && hi_r);

  assign cnt   = seg_b_r - seg_a_r;
  assign room  = 6'd32 - {1'b0, seg_a_r[4:0]};
  assign hi_ex = (cnt >= SPAN_W'(room)) ? 6'd32 : ({1'b0, seg_a_r[4:0]} + cnt[5:0]);

  always_comb begin
    for (int i = 0; i < WORD_WIDTH; i++) begin
      mask[i] = (6'(i) >= {1'b0, seg_a_r[4:0]}) && (6'(i) < hi_ex);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = (in_cmd == CMD_QUERY) ? ST_FIND : ST_LEN_RD;
      end
      ST_FIND: begin
        if (find_end) state_nxt = (f_hit_r && l_hit_r) ? ST_DIV_F : ST_LEN_RD;
      end
      ST_DIV_F:    state_nxt = ST_WAIT_F;
      ST_WAIT_F:   if (!div_busy) state_nxt = ST_DIV_L;
      ST_DIV_L:    state_nxt = ST_WAIT_L;
      ST_WAIT_L:   if (!div_busy) state_nxt = ST_FBIT_RD;
      ST_FBIT_RD:  state_nxt = ST_FBIT_CHK;
      ST_FBIT_CHK: state_nxt = ST_PLAN;
      ST_PLAN: begin
        if (!(last_r > first_r)) state_nxt = ST_LEN_RD;
        else if (same_rep)       state_nxt = ST_SCAN_RD;
        else if (cond_a)         state_nxt = ST_SCAN_RD;
        else                     state_nxt = ST_PART_B;
      end
      ST_PART_B:   state_nxt = (lri_r == '0) ? ST_SCAN_RD : ST_PART_C;
      ST_PART_C:   state_nxt = cond_c ? ST_C_RD_L : ST_LEN_RD;
      ST_C_RD_L:   state_nxt = ST_C_RD_F;
      ST_C_RD_F:   state_nxt = ST_C_SET;
      ST_C_SET:    state_nxt = ST_SCAN_RD;
      ST_SCAN_RD:  state_nxt = scan_end ? ret_r : ST_SCAN_CHK;
      ST_SCAN_CHK: state_nxt = ST_SCAN_RD;
      ST_LEN_RD:   state_nxt = (n_blk == '0) ? ST_DONE : ST_LEN_MUL;
      ST_LEN_MUL:  state_nxt = ST_LEN_ADD;
      ST_LEN_ADD:  state_nxt = ST_DONE;
      ST_DONE:     if (slot_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_tready = 1'b0;
    div_start = 1'b0;
    div_dvd   = first_r - f_start_r;
    div_dvs   = f_len_r;
    tb_addr   = IDX_W'(n_blk - CNT_W'(1));
    st_addr   = seg_a_r[OFF_W-1:BIT_W];
    unique case (state_r)
      ST_IDLE:    in_tready = 1'b1;
      ST_FIND:    tb_addr = idx_r[IDX_W-1:0];
      ST_DIV_F:   div_start = 1'b1;
      ST_DIV_L: begin
        div_start = 1'b1;
        div_dvd   = last_r - l_start_r;
        div_dvs   = l_len_r;
      end
      ST_FBIT_RD: st_addr = fpos[OFF_W-1:BIT_W];
      ST_C_RD_L:  tb_addr = lc_r[IDX_W-1:0];
      ST_C_RD_F:  tb_addr = fc_r[IDX_W-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          first_r <= in_first;
          last_r  <= in_last;
          idx_r   <= '0;
          pv_r    <= 1'b0;
          f_hit_r <= 1'b0;
          l_hit_r <= 1'b0;
          fbit_r  <= 1'b0;
          lo_r    <= 1'b0;
          hi_r    <= 1'b0;
          oor_r   <= 1'b0;
        end
      end
      ST_FIND: begin
        if (idx_r < n_blk) idx_r <= idx_r + CNT_W'(1);
        pv_r   <= idx_r < n_blk;
        pidx_r <= idx_r[IDX_W-1:0];
        if (pv_r && q_start_r <= first_r) begin
          f_hit_r   <= 1'b1;
          f_idx_r   <= pidx_r;
          f_start_r <= q_start_r;
          f_off_r   <= q_off_r;
          f_len_r   <= eff_len(q_len_r);
          f_rep_r   <= q_rep_r;
        end
        if (pv_r && q_start_r <= last_r) begin
          l_hit_r   <= 1'b1;
          l_idx_r   <= pidx_r;
          l_start_r <= q_start_r;
          l_off_r   <= q_off_r;
          l_len_r   <= eff_len(q_len_r);
        end
        if (find_end) oor_r <= !(f_hit_r && l_hit_r);
      end
      ST_WAIT_F: begin
        fri_r <= div_quo;
        fro_r <= div_rem;
      end
      ST_WAIT_L: begin
        lri_r <= div_quo;
        lro_r <= div_rem;
      end
      ST_FBIT_CHK: fbit_r <= st_data[fpos[BIT_W-1:0]];
      ST_PLAN: begin
        fc_r   <= $signed({2'b00, f_idx_r}) + (cond_a ? 8'sd1 : 8'sd0);
        lc_r   <= $signed({2'b00, l_idx_r});
        done_r <= 1'b0;
        if (same_rep) begin
          seg_a_r <= fpos;
          seg_b_r <= SPAN_W'(l_off_r) + SPAN_W'(lro_r);
          ret_r   <= ST_LEN_RD;
        end else begin
          seg_a_r <= fpos;
          seg_b_r <= SPAN_W'(f_off_r) + SPAN_W'(f_len_r);
          ret_r   <= ST_PART_B;
        end
      end
      ST_PART_B: begin
        if (lri_r == '0) begin
          seg_a_r <= SPAN_W'(l_off_r);
          seg_b_r <= SPAN_W'(l_off_r) + SPAN_W'(lro_r);
          ret_r   <= ST_PART_C;
          if (fc_r == lc_r) done_r <= 1'b1;
          else lc_r <= lc_r - 8'sd1;
        end
      end
      ST_C_RD_F: seg_b_r <= SPAN_W'(q_off_r) + SPAN_W'(eff_len(q_len_r));
      ST_C_SET: begin
        seg_a_r <= SPAN_W'(q_off_r);
        ret_r   <= ST_LEN_RD;
      end
      ST_SCAN_CHK: begin
        if ((st_data & mask) != '0)  hi_r <= 1'b1;
        if ((~st_data & mask) != '0) lo_r <= 1'b1;
        seg_a_r <= {seg_a_r[SPAN_W-1:BIT_W] + (SPAN_W-BIT_W)'(1), BIT_W'(0)};
      end
      ST_LEN_RD:  if (n_blk == '0) tlen_r <= '0;
      ST_LEN_MUL: prod_r <= TLEN_W'(eff_len(q_len_r)) * TLEN_W'(q_rep_r);
      ST_LEN_ADD: tlen_r <= TLEN_W'(q_start_r) + prod_r;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && slot_free) begin
      out_data_r <= {tlen_r, hi_r, lo_r, fbit_r};
      out_oor_r  <= oor_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_oor_r;

endmodule

@@ sv/rbtq_div.sv @@
// Restoring divider, one quotient bit per cycle.
module rbtq_div import rbtq_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [SAMPLE_W-1:0] dividend,
  input  logic [LEN_W-1:0]    divisor,
  output logic                busy,
  output logic [SAMPLE_W-1:0] quotient,
  output logic [LEN_W-1:0]    remainder
);

  logic [5:0]          cnt_r;
  logic                busy_r;
  logic [SAMPLE_W-1:0] quo_r;
  logic [LEN_W-1:0]    rem_r;
  logic [LEN_W-1:0]    dvs_r;
  logic [LEN_W:0]      trial;
  logic [LEN_W:0]      diff;
  logic                fits;

  assign trial = {rem_r, quo_r[SAMPLE_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
      quo_r  <= dividend;
      rem_r  <= '0;
      dvs_r  <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
      quo_r <= {quo_r[SAMPLE_W-2:0], fits};
      cnt_r <= cnt_r + 6'd1;
      if (cnt_r == 6'(SAMPLE_W - 1)) busy_r <= 1'b0;
    end
  end

  assign busy      = busy_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

@@ sv/rbtq_store.sv @@
// Trace bit store: one write port, one registered read port.
module rbtq_store import rbtq_pkg::*; (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [WADDR_W-1:0]    wr_addr,
  input  logic [WORD_WIDTH-1:0] wr_data,
  input  logic [WADDR_W-1:0]    rd_addr,
  output logic [WORD_WIDTH-1:0] rd_data
);

  logic [WORD_WIDTH-1:0] mem [STORE_WORDS];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

endmodule
